/* hw/rtl/srd_pkg.sv */
// ----------------------------------------------------------------------------
// srd_pkg: shared types and constants of the reflectance detector
// Sample and threshold widths, phase codes, register indexes and the structs
// that travel between the detector's modules.
// ----------------------------------------------------------------------------
`default_nettype none

package srd_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int CHANNELS    = 4;
    localparam int INPUT_CHANS = 4;
    localparam int THR_BITS    = 10;
    localparam int MASK_BITS   = 4;
    localparam int CMP_BITS    = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;

    localparam int ADDR_BITS   = 3;
    localparam int DATA_BITS   = 32;

    localparam logic [THR_BITS-1:0] WHITE_RESET = THR_BITS'(100);
    localparam logic [THR_BITS-1:0] BLACK_RESET = THR_BITS'(50);

    typedef enum logic [1:0] {
        PH_LED_ON  = 2'd0,
        PH_LIT     = 2'd1,
        PH_LED_OFF = 2'd2,
        PH_DECIDE  = 2'd3
    } t_phase;

    typedef enum logic [0:0] {
        REG_WHITE = 1'b0,
        REG_BLACK = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [THR_BITS-1:0] white;
        logic [THR_BITS-1:0] black;
    } t_thr;

    typedef struct packed {
        logic   accept;
        t_phase phase;
    } t_lane_ctl;

    typedef struct packed {
        logic [MASK_BITS-1:0] tape_mask;
        logic                 led_on;
    } t_result;

endpackage

`default_nettype wire

/* hw/rtl/srd_if.sv */
// ----------------------------------------------------------------------------
// srd_in_if / srd_out_if: valid-ready channels of the reflectance detector
// The input channel carries a phase and four ADC samples per word; the
// output channel carries the tape mask and the LED level.
// ----------------------------------------------------------------------------
`default_nettype none

interface srd_in_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      phase;
    logic [srd_pkg::SAMPLE_BITS-1:0] sample_right;
    logic [srd_pkg::SAMPLE_BITS-1:0] sample_mid;
    logic [srd_pkg::SAMPLE_BITS-1:0] sample_left;
    logic [srd_pkg::SAMPLE_BITS-1:0] sample_back;

    modport source (output valid, phase, sample_right, sample_mid, sample_left,
                    sample_back, input ready);
    modport sink   (input valid, phase, sample_right, sample_mid, sample_left,
                    sample_back, output ready);
endinterface

interface srd_out_if;
    logic                          valid;
    logic                          ready;
    logic [srd_pkg::MASK_BITS-1:0] tape_mask;
    logic                          led_on;

    modport source (output valid, tape_mask, led_on, input ready);
    modport sink   (input valid, tape_mask, led_on, output ready);
endinterface

`default_nettype wire

/* hw/rtl/srd_cfg.sv */
// ----------------------------------------------------------------------------
// srd_cfg: threshold registers behind an APB-style port
// Holds the white and black difference thresholds; writes land in the
// access phase and reads return the addressed register.
// ----------------------------------------------------------------------------
`default_nettype none

module srd_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [srd_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [srd_pkg::DATA_BITS-1:0] pwdata,
    output logic      [srd_pkg::DATA_BITS-1:0] prdata,
    output logic                               pready,
    output srd_pkg::t_thr                      o_thr
);
    import srd_pkg::*;

    t_thr     r_thr;
    t_thr     n_thr;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[2]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_comb begin
        n_thr = r_thr;
        if (w_wr) begin
            unique case (w_idx)
                REG_WHITE: n_thr.white = pwdata[THR_BITS-1:0];
                REG_BLACK: n_thr.black = pwdata[THR_BITS-1:0];
                default:   n_thr = r_thr;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr.white <= WHITE_RESET;
            r_thr.black <= BLACK_RESET;
        end else begin
            r_thr <= n_thr;
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_WHITE: prdata = DATA_BITS'(r_thr.white);
            REG_BLACK: prdata = DATA_BITS'(r_thr.black);
            default:   prdata = '0;
        endcase
    end

    assign o_thr = r_thr;

endmodule

`default_nettype wire

/* hw/rtl/srd_lane.sv */
// ----------------------------------------------------------------------------
// srd_lane: one channel of the synchronous detector
// Stores the lit sample, takes the absolute lit/dark difference and decides
// tape or white against the threshold that the last decision selected.
// ----------------------------------------------------------------------------
`default_nettype none

module srd_lane (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire srd_pkg::t_lane_ctl              i_ctl,
    input  wire logic [srd_pkg::SAMPLE_BITS-1:0] i_sample,
    input  wire srd_pkg::t_thr                   i_thr,
    output logic                                 o_tape_next
);
    import srd_pkg::*;

    logic [SAMPLE_BITS-1:0] r_lit;
    logic [SAMPLE_BITS-1:0] n_lit;
    logic                   r_use_black;
    logic                   n_use_black;
    logic                   r_tape;
    logic                   n_tape;
    logic [SAMPLE_BITS-1:0] w_diff;
    logic [THR_BITS-1:0]    w_thr;
    logic                   w_white;

    assign w_diff  = (i_sample >= r_lit) ? (i_sample - r_lit) : (r_lit - i_sample);
    assign w_thr   = r_use_black ? i_thr.black : i_thr.white;
    assign w_white = CMP_BITS'(w_diff) > CMP_BITS'(w_thr);

    always_comb begin
        n_lit       = r_lit;
        n_use_black = r_use_black;
        n_tape      = r_tape;
        if (i_ctl.accept) begin
            case (i_ctl.phase)
                PH_LIT: n_lit = i_sample;
                PH_DECIDE: begin
                    n_use_black = w_white;
                    n_tape      = !w_white;
                end
                default: n_lit = r_lit;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lit       <= '0;
            r_use_black <= 1'b0;
            r_tape      <= 1'b0;
        end else begin
            r_lit       <= n_lit;
            r_use_black <= n_use_black;
            r_tape      <= n_tape;
        end
    end

    assign o_tape_next = n_tape;

endmodule

`default_nettype wire

/* hw/rtl/srd_merge.sv */
// ----------------------------------------------------------------------------
// srd_merge: result merge and output buffer
// Packs the lane decisions into the tape mask, tracks the LED level and
// holds results in an output register backed by a skid register.
// ----------------------------------------------------------------------------
`default_nettype none

module srd_merge (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire srd_pkg::t_lane_ctl           i_ctl,
    input  wire logic [srd_pkg::CHANNELS-1:0] i_tape_next,
    output logic                              o_in_ready,
    srd_out_if.source                         o_out
);
    import srd_pkg::*;

    logic                 r_led;
    logic                 n_led;
    logic [MASK_BITS-1:0] w_mask;
    t_result              w_res;
    t_result              r_out;
    logic                 r_out_valid;
    t_result              r_skid;
    logic                 r_skid_valid;

    for (genvar b = 0; b < MASK_BITS; b++) begin : g_mask
        if (b < CHANNELS) begin : g_lane
            assign w_mask[b] = i_tape_next[b];
        end else begin : g_none
            assign w_mask[b] = 1'b0;
        end
    end

    always_comb begin
        n_led = r_led;
        if (i_ctl.accept) begin
            case (i_ctl.phase)
                PH_LED_ON:  n_led = 1'b1;
                PH_LED_OFF: n_led = 1'b0;
                default:    n_led = r_led;
            endcase
        end
    end

    assign w_res.tape_mask = w_mask;
    assign w_res.led_on    = n_led;
    assign o_in_ready      = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led        <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_led <= n_led;
            if (!r_out_valid || o_out.ready) begin
                r_out_valid  <= r_skid_valid || i_ctl.accept;
                r_skid_valid <= 1'b0;
            end else if (i_ctl.accept) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || o_out.ready) begin
            r_out <= r_skid_valid ? r_skid : w_res;
        end else if (i_ctl.accept) begin
            r_skid <= w_res;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.tape_mask = r_out.tape_mask;
    assign o_out.led_on    = r_out.led_on;

endmodule

`default_nettype wire

/* hw/rtl/synchronous_reflectance_detector.sv */
// ----------------------------------------------------------------------------
// synchronous_reflectance_detector: four-channel LED on/off tape detector
// Top level: threshold registers, one detector lane per channel, and the
// merge stage that packs and buffers the result word.
// ----------------------------------------------------------------------------
// The block takes one input word every clock cycle while input ready is high
// and returns exactly one result word per input word, registered when it is
// accepted. Each channel has its own lane, so all four decisions of a word are
// made in the cycle it is accepted; the result goes into an output register
// backed by one skid register, and input ready drops only while both hold
// words that the sink has not taken. Thresholds should be written while no
// word is in flight. There is no clearing pass after reset.
`default_nettype none

module synchronous_reflectance_detector (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    srd_in_if.sink                             i_in,
    srd_out_if.source                          o_out,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [srd_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [srd_pkg::DATA_BITS-1:0] pwdata,
    output logic      [srd_pkg::DATA_BITS-1:0] prdata,
    output logic                               pready
);
    import srd_pkg::*;

    t_thr                   w_thr;
    t_lane_ctl              w_ctl;
    logic                   w_in_ready;
    logic [CHANNELS-1:0]    w_tape_next;
    logic [SAMPLE_BITS-1:0] w_sample [CHANNELS];

    srd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_thr   (w_thr)
    );

    assign i_in.ready   = w_in_ready;
    assign w_ctl.accept = i_in.valid && w_in_ready;
    assign w_ctl.phase  = t_phase'(i_in.phase);

    for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
        if (ch == 0) begin : g_right
            assign w_sample[ch] = i_in.sample_right;
        end else if (ch == 1) begin : g_mid
            assign w_sample[ch] = i_in.sample_mid;
        end else if (ch == 2) begin : g_left
            assign w_sample[ch] = i_in.sample_left;
        end else if (ch == 3) begin : g_back
            assign w_sample[ch] = i_in.sample_back;
        end else begin : g_none
            assign w_sample[ch] = '0;
        end

        srd_lane u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_sample    (w_sample[ch]),
            .i_thr       (w_thr),
            .o_tape_next (w_tape_next[ch])
        );
    end

    srd_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_tape_next (w_tape_next),
        .o_in_ready  (w_in_ready),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

/* hw/rtl/srd_checker.sv */
// ----------------------------------------------------------------------------
// srd_checker: port-level checks of the reflectance detector
// Watches the channels at the top level's boundary and is bound to every
// instance of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module srd_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          i_in_ready,
    input wire logic [1:0]                    i_in_phase,
    input wire logic                          i_out_valid,
    input wire logic                          i_out_ready,
    input wire logic [srd_pkg::MASK_BITS-1:0] i_out_mask,
    input wire logic                          i_out_led
);
    import srd_pkg::*;

    logic w_acc;

    assign w_acc = i_in_valid && i_in_ready;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("Output valid after reset.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_mask) && $stable(i_out_led))
        else $error("Stalled output word changed.");

    a_led_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && !i_out_valid && (t_phase'(i_in_phase) == PH_LED_ON) |=>
            i_out_valid && i_out_led)
        else $error("LED-on word did not report the LED on.");

    a_led_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && !i_out_valid && (t_phase'(i_in_phase) == PH_LED_OFF) |=>
            i_out_valid && !i_out_led)
        else $error("LED-off word did not report the LED off.");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("Input stalled with no output word pending.");

endmodule

bind synchronous_reflectance_detector srd_checker u_srd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_phase  (i_in.phase),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_mask  (o_out.tape_mask),
    .i_out_led   (o_out.led_on)
);

`default_nettype wire
